// File: sv/vigenere_char_cipher_unit_assert.svh
// ---------------------------------------------------------------------------
// Vigenere char cipher unit assertion macros
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef VIGENERE_CHAR_CIPHER_UNIT_ASSERT_SVH
`define VIGENERE_CHAR_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication, muted while reset is high.
`define VCC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vigenere_char_cipher_unit: check failed");

// Next-cycle implication, muted while reset is high.
`define VCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vigenere_char_cipher_unit: check failed");

// Next-cycle implication that also holds across reset.
`define VCC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vigenere_char_cipher_unit: check failed");

`endif

// File: sv/vcc_pkg.sv
// ---------------------------------------------------------------------------
// Vigenere char cipher package
// Widths, command and register codes, character constants, shared types.
// ---------------------------------------------------------------------------
package vcc_pkg;

   localparam int MAX_KEY_BYTES_DEFAULT = 32;
   localparam int TEXT_W                = 8;
   localparam int CMD_W                 = 2;
   localparam int LEN_W                 = 6;
   localparam int CSR_INDEX_W           = 3;
   localparam int CSR_DATA_W            = 64;
   localparam int KEY_BYTES_PER_REG     = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENCRYPT = 2'd0,
      CMD_DECRYPT = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KEY_LENGTH         = 3'd0,
      REG_KEY_BYTES_LOW      = 3'd1,
      REG_KEY_BYTES_MID_LOW  = 3'd2,
      REG_KEY_BYTES_MID_HIGH = 3'd3,
      REG_KEY_BYTES_HIGH     = 3'd4
   } csr_index_type;

   localparam logic [TEXT_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [TEXT_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [TEXT_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [TEXT_W-1:0] CHAR_LOWER_Z = 8'h7A;

   // Key position control from the datapath to the key store
   typedef struct packed {
      logic advance;
      logic restart;
   } pos_ctrl_type;

endpackage

// File: sv/vigenere_char_cipher_unit.sv
// ---------------------------------------------------------------------------
// Vigenere char cipher unit
// Streaming case-preserving Vigenere coder, one byte per word.
// ---------------------------------------------------------------------------
// The unit takes one word per clock on the req_ channel while req_tready is
// high and, for encrypt and decrypt commands, returns one word on the
// rsp_ channel via the input register and the result register; a restart
// command resets the key position and returns nothing. Sustained rate, with
// rsp_tready high, is one word per cycle through the combinational coder;
// stalls on rsp_tready hold the result register and the input register
// still takes one more word. The key (length and up to MAX_KEY_BYTES bytes)
// lives in flip-flops written through the csr_ port; write it only while no
// word is in flight. Letters rotate within their own case, other bytes pass
// through, and every encrypt or decrypt word moves the key position on by one.
// There is no clearing pass after reset.
module vigenere_char_cipher_unit
   import vcc_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // Request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TEXT_W-1:0]      req_tdata,  // [7:0] text_byte
   input  logic [CMD_W-1:0]       req_tuser,  // [1:0] cmd
   // Response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TEXT_W-1:0]      rsp_tdata   // [7:0] out_byte
);

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff;
   logic [TEXT_W-1:0] s1_byte_ff;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TEXT_W-1:0] rsp_byte_ff;

   logic              req_accept;
   logic              out_free;
   logic              s1_has_result;
   logic              s1_restart;
   logic              s1_advance;
   pos_ctrl_type      pos_ctrl;
   logic [TEXT_W-1:0] key_byte;
   logic [TEXT_W-1:0] coded_byte;

   // Decode the held command: encrypt and decrypt produce a word,
   // restart only clears the key position, the spare code is dropped
   always_comb begin
      s1_has_result = 1'b0;
      s1_restart    = 1'b0;
      unique case (s1_cmd_ff) inside
         CMD_ENCRYPT, CMD_DECRYPT: s1_has_result = 1'b1;
         CMD_RESTART:              s1_restart    = 1'b1;
         default: begin
            s1_has_result = 1'b0;
            s1_restart    = 1'b0;
         end
      endcase
   end

   // The result register can load when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // Commands with no result leave the input register without waiting
   assign s1_advance = s1_valid_ff && (!s1_has_result || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   assign pos_ctrl.advance = s1_advance && s1_has_result;
   assign pos_ctrl.restart = s1_advance && s1_restart;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pos_ctrl.advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff  <= cmd_type'(req_tuser);
         s1_byte_ff <= req_tdata;
      end
      if (pos_ctrl.advance) begin
         rsp_byte_ff <= coded_byte;
      end
   end

   vcc_key_store #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_key_store (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pos_ctrl  (pos_ctrl),
      .key_byte  (key_byte)
   );

   vcc_coder u_coder (
      .decrypt   (s1_cmd_ff == CMD_DECRYPT),
      .text_byte (s1_byte_ff),
      .key_byte  (key_byte),
      .out_byte  (coded_byte)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;

endmodule

// File: sv/vcc_key_store.sv
// ---------------------------------------------------------------------------
// Vigenere key store
// Key length and key byte registers, key position counter, key byte read.
// ---------------------------------------------------------------------------
module vcc_key_store
   import vcc_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEFAULT,
   localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  pos_ctrl_type           pos_ctrl,
   output logic [TEXT_W-1:0]      key_byte
);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [TEXT_W-1:0] key_ff [MAX_KEY_BYTES];
   logic [TEXT_W-1:0] key_in [MAX_KEY_BYTES];
   logic [LEN_W-1:0]  pos_next;
   logic              pos_wrap;

   always_comb begin
      len_in = len_ff;
      if (csr_we && csr_index == REG_KEY_LENGTH) begin
         len_in = csr_wdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
      end else begin
         len_ff <= len_in;
      end
   end

   for (genvar g = 0; g < MAX_KEY_BYTES; g++) begin : g_key
      localparam int Word = g / KEY_BYTES_PER_REG;
      localparam int Lane = g % KEY_BYTES_PER_REG;

      always_comb begin
         key_in[g] = key_ff[g];
         if (csr_we &&
             csr_index == CSR_INDEX_W'(REG_KEY_BYTES_LOW) + CSR_INDEX_W'(Word)) begin
            key_in[g] = csr_wdata[Lane*TEXT_W +: TEXT_W];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[g] <= '0;
         end else begin
            key_ff[g] <= key_in[g];
         end
      end
   end

   // Wrap at the key length, saturated to the store depth; zero wraps at once
   assign pos_next = LEN_W'(pos_ff) + LEN_W'(1);
   assign pos_wrap = (pos_next >= len_ff) || (pos_next >= LEN_W'(MAX_KEY_BYTES));

   always_comb begin
      pos_in = pos_ff;
      if (pos_ctrl.restart) begin
         pos_in = '0;
      end else if (pos_ctrl.advance) begin
         pos_in = pos_wrap ? '0 : pos_next[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign key_byte = key_ff[pos_ff];

endmodule

// File: sv/vcc_coder.sv
// ---------------------------------------------------------------------------
// Vigenere byte coder
// Case-preserving rotation of one byte by the shift of one key byte.
// ---------------------------------------------------------------------------
module vcc_coder
   import vcc_pkg::*;
(
   input  logic              decrypt,
   input  logic [TEXT_W-1:0] text_byte,
   input  logic [TEXT_W-1:0] key_byte,
   output logic [TEXT_W-1:0] out_byte
);

   localparam logic [5:0] ALPHA_LEN = 6'd26;

   logic              key_upper;
   logic [6:0]        key_diff;
   logic [4:0]        shift;
   logic              is_upper;
   logic              is_lower;
   logic [TEXT_W-1:0] base;
   logic [4:0]        offset;
   logic [5:0]        sum;
   logic [5:0]        sum_mod;

   // Shift of the key byte: 'A'-'Z' give 0 to 25, bytes above 'a' their distance from 'a' mod 26, all others zero
   assign key_upper = (key_byte >= CHAR_UPPER_A) && (key_byte <= CHAR_UPPER_Z);
   assign key_diff  = 7'(key_byte - CHAR_LOWER_A);

   always_comb begin
      shift = '0;
      if (key_byte[TEXT_W-1]) begin
         shift = '0;
      end else if (key_upper) begin
         shift = 5'(key_byte - CHAR_UPPER_A);
      end else if (key_byte > CHAR_LOWER_A) begin
         shift = (key_diff >= 7'(ALPHA_LEN)) ? 5'(key_diff - 7'(ALPHA_LEN))
                                             : 5'(key_diff);
      end
   end

   assign is_upper = (text_byte >= CHAR_UPPER_A) && (text_byte <= CHAR_UPPER_Z);
   assign is_lower = (text_byte >= CHAR_LOWER_A) && (text_byte <= CHAR_LOWER_Z);
   assign base     = is_upper ? CHAR_UPPER_A : CHAR_LOWER_A;
   assign offset   = 5'(text_byte - base);

   assign sum = decrypt ? 6'(offset) + ALPHA_LEN - 6'(shift)
                        : 6'(offset) + 6'(shift);
   assign sum_mod = (sum >= ALPHA_LEN) ? sum - ALPHA_LEN : sum;

   assign out_byte = (is_upper || is_lower) ? base + TEXT_W'(sum_mod) : text_byte;

endmodule

// File: sv/vcc_checker.sv
// ---------------------------------------------------------------------------
// Vigenere char cipher checker
// Port-level checks on the cipher unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "vigenere_char_cipher_unit_assert.svh"

module vcc_checker
   import vcc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [TEXT_W-1:0] req_tdata,
   input logic [CMD_W-1:0]  req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [TEXT_W-1:0] rsp_tdata
);

   logic req_coding;
   logic req_non_letter;

   assign req_coding = req_tvalid && req_tready &&
                       (req_tuser == CMD_ENCRYPT || req_tuser == CMD_DECRYPT);
   assign req_non_letter = (req_tdata < CHAR_UPPER_A) ||
                           (req_tdata > CHAR_UPPER_Z && req_tdata < CHAR_LOWER_A) ||
                           (req_tdata > CHAR_LOWER_Z);

   // Reset empties both registers
   `VCC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid && req_tready)

   // With the output empty nothing can block the input side
   `VCC_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // A stalled word holds
   `VCC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

   // A fresh output word traces back to an accepted word that passed the input register
   `VCC_ASSERT_IMPLY(a_rise_from_accept, clock, reset, $rose(rsp_tvalid),
                     $past(req_tvalid && req_tready, 2))

   // Non-letters pass through unchanged
   `VCC_ASSERT_IMPLY(a_non_letter_pass, clock, reset,
                     $rose(rsp_tvalid) && $past(req_coding && req_non_letter, 2),
                     rsp_tdata == $past(req_tdata, 2))

endmodule

bind vigenere_char_cipher_unit vcc_checker u_vcc_checker (.*);
